>>> sv/quadrature_tach_period_meter_core_defines.svh
// Assertion macros for the quadrature tachometer period meter
`ifndef QUADRATURE_TACH_PERIOD_METER_CORE_DEFINES_SVH
`define QUADRATURE_TACH_PERIOD_METER_CORE_DEFINES_SVH

// Check on every clock edge outside reset
`define QTPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qtpm assertion failed");

// Check on every clock edge, reset included
`define QTPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qtpm reset assertion failed");

`endif

>>> sv/qtpm_pkg.sv
// Shared types and constants for the quadrature tachometer period meter
package qtpm_pkg;

  localparam int DEF_TIME_WIDTH  = 32;
  localparam int DEF_COUNT_WIDTH = 8;
  localparam int STAMP_WIDTH     = 32;
  localparam int PERIOD_WIDTH    = 32;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam int CFG_IDX_WIDTH   = 2;

  localparam logic [CFG_DATA_WIDTH-1:0] TICKS_RESET = 8'd12;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_TICKS_A = 2'd0,
    REG_TICKS_B = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_CHANGE_A = 2'd0,
    ACT_CHANGE_B = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef struct packed {
    action_t                  action;
    logic                     level_a;
    logic                     level_b;
    logic [STAMP_WIDTH-1:0]   time_us;
  } qtpm_item_t;

  typedef struct packed {
    logic                     dir_e;
    logic                     dir_f;
    logic [PERIOD_WIDTH-1:0]  period_a;
    logic [PERIOD_WIDTH-1:0]  period_b;
  } qtpm_result_t;

  typedef struct packed {
    logic in_stall;
    logic s1_valid;
    logic s1_fire;
  } qtpm_flow_t;

endpackage

>>> sv/qtpm_in_stage.sv
// Input register stage with stall generation
module qtpm_in_stage
  import qtpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  qtpm_item_t in_item,
  input  logic       advance,
  output qtpm_flow_t flow,
  output qtpm_item_t s1_item
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  qtpm_item_t s1_item_r;
  logic       in_stall;
  logic       in_fire;

  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  assign flow.in_stall = in_stall;
  assign flow.s1_valid = s1_valid_r;
  assign flow.s1_fire  = s1_valid_r && advance;
  assign s1_item       = s1_item_r;

endmodule

>>> sv/qtpm_update.sv
// Direction decode, tick counting and period capture state
module qtpm_update
  import qtpm_pkg::*;
#(
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic                      commit,
  input  qtpm_item_t                item,
  output qtpm_result_t              result
);

  logic [CFG_DATA_WIDTH-1:0] ticks_a_r, ticks_b_r;

  logic                   prev_a_r, prev_a_nxt;
  logic                   prev_b_r, prev_b_nxt;
  logic                   lv_seeded_r, lv_seeded_nxt;
  logic                   dir_e_r, dir_e_nxt;
  logic                   dir_f_r, dir_f_nxt;
  logic [COUNT_WIDTH-1:0] cnt_a_r, cnt_a_nxt;
  logic [COUNT_WIDTH-1:0] cnt_b_r, cnt_b_nxt;
  logic [TIME_WIDTH-1:0]  cap_a_r, cap_a_nxt;
  logic [TIME_WIDTH-1:0]  cap_b_r, cap_b_nxt;
  logic                   ts_a_r, ts_a_nxt;
  logic                   ts_b_r, ts_b_nxt;
  logic [TIME_WIDTH-1:0]  per_a_r, per_a_nxt;
  logic [TIME_WIDTH-1:0]  per_b_r, per_b_nxt;
  logic                   alive_r, alive_nxt;

  logic [TIME_WIDTH+STAMP_WIDTH-1:0]      now_ext;
  logic [TIME_WIDTH-1:0]                  now;
  logic [COUNT_WIDTH+CFG_DATA_WIDTH-1:0]  lim_a_ext, lim_b_ext;
  logic [COUNT_WIDTH-1:0]                 lim_a, lim_b;
  logic [COUNT_WIDTH-1:0]                 inc_a, inc_b;
  logic [TIME_WIDTH-1:0]                  base_a, base_b;
  logic                                   pa, pb, a, b;
  logic                                   e_calc, f_calc;
  logic [TIME_WIDTH+PERIOD_WIDTH-1:0]     per_a_ext, per_b_ext;

  assign now_ext   = {{TIME_WIDTH{1'b0}}, item.time_us};
  assign now       = now_ext[TIME_WIDTH-1:0];
  assign lim_a_ext = {{COUNT_WIDTH{1'b0}}, ticks_a_r};
  assign lim_b_ext = {{COUNT_WIDTH{1'b0}}, ticks_b_r};
  assign lim_a     = lim_a_ext[COUNT_WIDTH-1:0];
  assign lim_b     = lim_b_ext[COUNT_WIDTH-1:0];
  assign inc_a     = cnt_a_r + COUNT_WIDTH'(1);
  assign inc_b     = cnt_b_r + COUNT_WIDTH'(1);
  assign base_a    = ts_a_r ? cap_a_r : now;
  assign base_b    = ts_b_r ? cap_b_r : now;

  assign a  = item.level_a;
  assign b  = item.level_b;
  assign pa = lv_seeded_r ? prev_a_r : a;
  assign pb = lv_seeded_r ? prev_b_r : b;

  assign e_calc = (!pb && !a) || (!pa && b) || (pb && a) || (pa && !b);
  assign f_calc = (!pa && !b) || (pb && !b) || (pa && b) || (!pb && a);

  always_comb begin
    prev_a_nxt    = prev_a_r;
    prev_b_nxt    = prev_b_r;
    lv_seeded_nxt = lv_seeded_r;
    dir_e_nxt     = dir_e_r;
    dir_f_nxt     = dir_f_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    cap_a_nxt     = cap_a_r;
    cap_b_nxt     = cap_b_r;
    ts_a_nxt      = ts_a_r;
    ts_b_nxt      = ts_b_r;
    per_a_nxt     = per_a_r;
    per_b_nxt     = per_b_r;
    alive_nxt     = alive_r;
    case (item.action)
      ACT_CHANGE_A: begin
        cap_a_nxt     = base_a;
        ts_a_nxt      = 1'b1;
        prev_a_nxt    = a;
        prev_b_nxt    = b;
        lv_seeded_nxt = 1'b1;
        dir_e_nxt     = e_calc;
        dir_f_nxt     = f_calc;
        if (a) begin
          alive_nxt = 1'b1;
          cnt_a_nxt = inc_a;
          if (inc_a == lim_a) begin
            per_a_nxt = now - base_a;
            cap_a_nxt = now;
            cnt_a_nxt = '0;
          end
        end
      end
      ACT_CHANGE_B: begin
        cap_b_nxt     = base_b;
        ts_b_nxt      = 1'b1;
        prev_a_nxt    = a;
        prev_b_nxt    = b;
        lv_seeded_nxt = 1'b1;
        dir_e_nxt     = e_calc;
        dir_f_nxt     = f_calc;
        if (b) begin
          cnt_b_nxt = inc_b;
          if (inc_b == lim_b) begin
            per_b_nxt = now - base_b;
            cap_b_nxt = now;
            cnt_b_nxt = '0;
          end
        end
      end
      ACT_TICK: begin
        if (alive_r) begin
          alive_nxt = 1'b0;
        end else begin
          per_a_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_a_r   <= TICKS_RESET;
      ticks_b_r   <= TICKS_RESET;
      prev_a_r    <= 1'b0;
      prev_b_r    <= 1'b0;
      lv_seeded_r <= 1'b0;
      dir_e_r     <= 1'b1;
      dir_f_r     <= 1'b1;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      cap_a_r     <= '0;
      cap_b_r     <= '0;
      ts_a_r      <= 1'b0;
      ts_b_r      <= 1'b0;
      per_a_r     <= '0;
      per_b_r     <= '0;
      alive_r     <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_TICKS_A)) begin
        ticks_a_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_TICKS_B)) begin
        ticks_b_r <= cfg_data;
      end
      if (commit) begin
        prev_a_r    <= prev_a_nxt;
        prev_b_r    <= prev_b_nxt;
        lv_seeded_r <= lv_seeded_nxt;
        dir_e_r     <= dir_e_nxt;
        dir_f_r     <= dir_f_nxt;
        cnt_a_r     <= cnt_a_nxt;
        cnt_b_r     <= cnt_b_nxt;
        cap_a_r     <= cap_a_nxt;
        cap_b_r     <= cap_b_nxt;
        ts_a_r      <= ts_a_nxt;
        ts_b_r      <= ts_b_nxt;
        per_a_r     <= per_a_nxt;
        per_b_r     <= per_b_nxt;
        alive_r     <= alive_nxt;
      end
    end
  end

  assign per_a_ext       = {{PERIOD_WIDTH{1'b0}}, per_a_nxt};
  assign per_b_ext       = {{PERIOD_WIDTH{1'b0}}, per_b_nxt};
  assign result.dir_e    = dir_e_nxt;
  assign result.dir_f    = dir_f_nxt;
  assign result.period_a = per_a_ext[PERIOD_WIDTH-1:0];
  assign result.period_b = per_b_ext[PERIOD_WIDTH-1:0];

endmodule

>>> sv/quadrature_tach_period_meter_core.sv
// Top level of the quadrature tachometer period meter
//
//   channel  handshake            payload
//   in       in_valid/in_stall    in_action, in_level_a, in_level_b, in_time_us
//   out      out_valid/out_stall  out_dir_e, out_dir_f, out_period_a, out_period_b
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless a stalled result holds the flow.
// Latency is set by the input register and the result register around the update.
// Reset (rst_n low, synchronous) empties both stages and restores counts and periods.
// A stalled result holds; the input register still takes one more item behind it.
// cfg_ready is always high.
`include "quadrature_tach_period_meter_core_defines.svh"
module quadrature_tach_period_meter_core
  import qtpm_pkg::*;
#(
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic                      in_level_a,
  input  logic                      in_level_b,
  input  logic [STAMP_WIDTH-1:0]    in_time_us,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_dir_e,
  output logic                      out_dir_f,
  output logic [PERIOD_WIDTH-1:0]   out_period_a,
  output logic [PERIOD_WIDTH-1:0]   out_period_b,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  qtpm_item_t   in_item;
  qtpm_item_t   s1_item;
  qtpm_flow_t   flow;
  qtpm_result_t res_nxt;
  qtpm_result_t res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         advance;

  assign in_item.action  = action_t'(in_action);
  assign in_item.level_a = in_level_a;
  assign in_item.level_b = in_level_b;
  assign in_item.time_us = in_time_us;

  assign advance   = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  qtpm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .flow     (flow),
    .s1_item  (s1_item)
  );

  qtpm_update #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .commit    (flow.s1_fire),
    .item      (s1_item),
    .result    (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = flow.s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign in_stall     = flow.in_stall;
  assign out_valid    = out_valid_r;
  assign out_dir_e    = res_r.dir_e;
  assign out_dir_f    = res_r.dir_f;
  assign out_period_a = res_r.period_a;
  assign out_period_b = res_r.period_b;

  `QTPM_ASSERT(a_stall_needs_item, in_stall |-> flow.s1_valid && out_valid_r)
  `QTPM_ASSERT(a_fire_fills_out, flow.s1_fire |=> out_valid_r)
  `QTPM_ASSERT(a_stall_holds_stage, in_stall |=> $stable(s1_item))
  `QTPM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !flow.s1_valid)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the quadrature tachometer period meter core
module testbench;
  import qtpm_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int IDLE_LIMIT  = 1000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_action = ACT_NONE;
  logic                      in_level_a = 1'b0;
  logic                      in_level_b = 1'b0;
  logic [STAMP_WIDTH-1:0]    in_time_us = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_dir_e;
  logic                      out_dir_f;
  logic [PERIOD_WIDTH-1:0]   out_period_a;
  logic [PERIOD_WIDTH-1:0]   out_period_b;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  reg_idx_t                  cfg_index = REG_TICKS_A;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  always #HALF_PERIOD clk = ~clk;

  quadrature_tach_period_meter_core uut (.*);

  // predicted meter state
  logic [7:0]  ticks_a_cfg, ticks_b_cfg;
  logic        last_a, last_b, levels_known;
  logic        dir_e_q, dir_f_q;
  logic [7:0]  count_a, count_b;
  logic [31:0] mark_a, mark_b;
  logic        mark_a_set, mark_b_set;
  logic [31:0] period_a_q, period_b_q;
  logic        alive;

  qtpm_result_t pending_readings[$];
  qtpm_result_t next_reading;
  int           mismatch_count = 0;
  int           idle_odds = 0;
  int           stall_left = 0;
  int           quiet_cycles = 0;
  logic [31:0]  stamp_us;
  int           enc_pos = 0;
  int           spin = 1;
  logic         enc_a = 1'b0;
  logic         enc_b = 1'b0;

  function automatic void clear_meter();
    ticks_a_cfg  = TICKS_RESET;
    ticks_b_cfg  = TICKS_RESET;
    last_a       = 1'b0;
    last_b       = 1'b0;
    levels_known = 1'b0;
    dir_e_q      = 1'b1;
    dir_f_q      = 1'b1;
    count_a      = '0;
    count_b      = '0;
    mark_a       = '0;
    mark_b       = '0;
    mark_a_set   = 1'b0;
    mark_b_set   = 1'b0;
    period_a_q   = '0;
    period_b_q   = '0;
    alive        = 1'b0;
  endfunction

  function automatic void decode_direction(input logic la, input logic lb);
    if (!levels_known) begin
      last_a       = la;
      last_b       = lb;
      levels_known = 1'b1;
    end
    dir_e_q = (!last_b && !la) || (!last_a && lb) || (last_b && la) || (last_a && !lb);
    dir_f_q = (!last_a && !lb) || (last_b && !lb) || (last_a && lb) || (!last_b && la);
    last_a  = la;
    last_b  = lb;
  endfunction

  function automatic void advance_count(inout logic [7:0] count, input logic [7:0] limit,
                                        inout logic [31:0] mark, inout logic [31:0] period,
                                        input logic [31:0] ts);
    count = count + 8'd1;
    if (count == limit) begin
      period = ts - mark;
      mark   = ts;
      count  = '0;
    end
  endfunction

  function automatic qtpm_result_t meter_step(input action_t act, input logic la,
                                              input logic lb, input logic [31:0] ts);
    qtpm_result_t r;
    case (act)
      ACT_CHANGE_A: begin
        if (!mark_a_set) begin
          mark_a     = ts;
          mark_a_set = 1'b1;
        end
        decode_direction(la, lb);
        if (la) begin
          alive = 1'b1;
          advance_count(count_a, ticks_a_cfg, mark_a, period_a_q, ts);
        end
      end
      ACT_CHANGE_B: begin
        if (!mark_b_set) begin
          mark_b     = ts;
          mark_b_set = 1'b1;
        end
        decode_direction(la, lb);
        if (lb) advance_count(count_b, ticks_b_cfg, mark_b, period_b_q, ts);
      end
      ACT_TICK: begin
        if (alive) alive = 1'b0;
        else period_a_q = '0;
      end
      default: ;
    endcase
    r.dir_e    = dir_e_q;
    r.dir_f    = dir_f_q;
    r.period_a = period_a_q;
    r.period_b = period_b_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch %s: got %h, expected %h", what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic send_event(input action_t act, input logic la, input logic lb,
                            input logic [31:0] ts);
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_level_a <= la;
    in_level_b <= lb;
    in_time_us <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(meter_step(act, la, lb, ts));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ticks(input logic [7:0] ta, input logic [7:0] tb);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TICKS_A;
    cfg_data  <= ta;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ticks_a_cfg = ta;
    cfg_index <= REG_TICKS_B;
    cfg_data  <= tb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ticks_b_cfg = tb;
    cfg_valid <= 1'b0;
  endtask

  task automatic quadrature_run(input int count, input int odds);
    logic na, nb;
    idle_odds = odds;
    for (int i = 0; i < count; i++) begin
      stamp_us += $urandom_range(1, 3000);
      if ($urandom_range(0, 19) == 0) stamp_us = $urandom;
      case ($urandom_range(0, 9))
        0, 1: send_event(ACT_TICK, enc_a, enc_b, stamp_us);
        2: send_event(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom);
        3: send_event($urandom_range(0, 1) ? ACT_CHANGE_A : ACT_CHANGE_B,
                      enc_a, enc_b, stamp_us);
        default: begin
          if ($urandom_range(0, 15) == 0) spin = -spin;
          enc_pos = (enc_pos + spin) & 3;
          na = (enc_pos == 1) || (enc_pos == 2);
          nb = (enc_pos >= 2);
          send_event((na != enc_a) ? ACT_CHANGE_A : ACT_CHANGE_B, na, nb, stamp_us);
          enc_a = na;
          enc_b = nb;
        end
      endcase
    end
  endtask

  task automatic test_first_events();
    idle_odds = 6;
    send_event(ACT_TICK, 1'b0, 1'b0, 32'h0000_0000);
    send_event(ACT_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_event(ACT_CHANGE_B, 1'b1, 1'b0, 32'h0000_0010);
    send_event(ACT_CHANGE_B, 1'b1, 1'b1, 32'h0000_0020);
    send_event(ACT_CHANGE_A, 1'b0, 1'b1, 32'h0000_0030);
    send_event(ACT_CHANGE_A, 1'b1, 1'b1, 32'h0000_0040);
    send_event(ACT_NONE, 1'b0, 1'b0, 32'h5555_AAAA);
  endtask

  task automatic test_short_periods();
    set_ticks(8'd1, 8'd1);
    send_event(ACT_CHANGE_A, 1'b1, 1'b0, 32'hFFFF_FFF0);
    send_event(ACT_CHANGE_A, 1'b1, 1'b1, 32'h0000_0010);
    send_event(ACT_CHANGE_B, 1'b0, 1'b1, 32'h8000_0000);
    send_event(ACT_CHANGE_B, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_event(ACT_CHANGE_A, 1'b0, 1'b0, 32'hAAAA_5555);
    send_event(ACT_CHANGE_B, 1'b0, 1'b0, 32'h0F0F_F0F0);
  endtask

  task automatic test_alive_timeout();
    send_event(ACT_TICK, 1'b0, 1'b0, 32'h0000_1000);
    send_event(ACT_TICK, 1'b0, 1'b0, 32'h0000_2000);
    send_event(ACT_TICK, 1'b1, 1'b1, 32'h0000_3000);
    send_event(ACT_CHANGE_A, 1'b0, 1'b1, 32'h0000_4000);
    send_event(ACT_TICK, 1'b0, 1'b1, 32'h0000_5000);
    send_event(ACT_CHANGE_A, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_event(ACT_TICK, 1'b1, 1'b0, 32'h0000_0001);
    send_event(ACT_TICK, 1'b1, 1'b0, 32'h0000_0002);
  endtask

  task automatic test_count_wraparound();
    set_ticks(8'd255, 8'd60);
    idle_odds = 8;
    stamp_us  = 32'hFFFC_0000;
    for (int i = 0; i < 260; i++) begin
      stamp_us += $urandom_range(1, 2000);
      send_event(ACT_CHANGE_A, 1'b1, 1'($urandom_range(0, 1)), stamp_us);
      if (i % 4 == 3) begin
        stamp_us += $urandom_range(1, 2000);
        send_event(ACT_CHANGE_B, 1'($urandom_range(0, 1)), 1'b1, stamp_us);
      end
    end
    // lower both limits below the running counts
    set_ticks(8'd3, 8'd2);
    idle_odds = 5;
    for (int i = 0; i < 256; i++) begin
      stamp_us += $urandom_range(1, 2000);
      send_event(ACT_CHANGE_A, 1'b1, 1'($urandom_range(0, 1)), stamp_us);
      stamp_us += $urandom_range(1, 2000);
      send_event(ACT_CHANGE_B, 1'($urandom_range(0, 1)), 1'b1, stamp_us);
    end
  endtask

  task automatic test_quadrature_runs();
    stamp_us = $urandom;
    set_ticks(8'd1, 8'd255);
    quadrature_run(140, 6);
    set_ticks(8'd255, 8'd1);
    quadrature_run(140, 0);
    set_ticks(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    quadrature_run(140, 3);
    set_ticks(8'd2, 8'd5);
    quadrature_run(140, 10);
  endtask

  task automatic test_closing_burst();
    set_ticks(8'd7, 8'd12);
    quadrature_run(100, 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no event pending", '0, '0);
      end else begin
        next_reading = pending_readings.pop_front();
        if (out_dir_e !== next_reading.dir_e)
          report_mismatch("dir_e", 32'(out_dir_e), 32'(next_reading.dir_e));
        if (out_dir_f !== next_reading.dir_f)
          report_mismatch("dir_f", 32'(out_dir_f), 32'(next_reading.dir_f));
        if (out_period_a !== next_reading.period_a)
          report_mismatch("period_a", out_period_a, next_reading.period_a);
        if (out_period_b !== next_reading.period_b)
          report_mismatch("period_b", out_period_b, next_reading.period_b);
      end
    end
    if (idle_odds == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!out_stall && $urandom_range(0, idle_odds) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    clear_meter();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_first_events();
    test_short_periods();
    test_alive_timeout();
    test_count_wraparound();
    test_quadrature_runs();
    test_closing_burst();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
